@@ hdl/lru_page_replacement_unit_macros.svh @@
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_macros
// Assertion helpers shared by the lru page replacement rtl.
// ----------------------------------------------------------------------------
// each macro expects clk and arst_n to be visible where it is used
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define LRU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LRU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// lru_pkg
// Shared widths, reset values and the decision record passed from the
// frame selection logic to the frame store.
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int PAGE_BITS = 16;
	localparam int FRAME_W   = 3;
	localparam int CFG_W     = 4;
	localparam int COUNT_W   = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [COUNT_W-1:0]   count_t;

	typedef struct packed {
		logic fault;  // page not resident
		logic fill;   // fault served by an empty frame
		logic evict;  // fault served by replacing the oldest frame
	} decision_t;

endpackage

@@ hdl/lru_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Least recently used page replacement over a small set of page frames.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy
//   stays low, so a new page reference may be issued every cycle.
//   The request is registered, looked up against all frames in parallel and
//   the frame store, fault counter and result registers update at the next
//   edge. done is high for one cycle with fault, frame, evicted_valid,
//   evicted_page and fault_total from the edge after the request was taken.
//   Throughput is one request per cycle, set by the parallel compare and rank
//   update over MAX_FRAMES frames. There is no output back-pressure: a result
//   is lost if not sampled during its done cycle. frames_in_use is written
//   through cfg_valid/cfg_ready/cfg_data; the user must write it only while no
//   request is in flight, which the block itself does not enforce. cfg_ready
//   is always high.
//   Reset (arst_n low) empties all frames, clears ranks and the fault count,
//   sets frames_in_use to 8 and drops any request in flight.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit import lru_pkg::*; #(
	parameter int MAX_FRAMES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  page_t             page,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              done,
	output logic              fault,
	output logic [FRAME_W-1:0] frame,
	output logic              evicted_valid,
	output page_t             evicted_page,
	output count_t            fault_total
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	logic [CFG_W-1:0]      frames_in_use_q;
	logic                  valid_s1;
	page_t                 page_s1;
	count_t                fault_count_q;
	count_t                fault_count_nxt;

	page_t                 pages  [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid;
	logic [IDX_W-1:0]      rank   [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] active;
	decision_t             dec;
	logic [IDX_W-1:0]      frame_idx;
	page_t                 evict_page;
	logic [IDX_W+FRAME_W-1:0] frame_wide;

	logic                  done_s2;
	logic                  fault_s2;
	logic [FRAME_W-1:0]    frame_s2;
	logic                  evicted_valid_s2;
	page_t                 evicted_page_s2;
	count_t                fault_total_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			page_s1 <= page;
		end
	end

	lru_select #(
		.MAX_FRAMES (MAX_FRAMES),
		.IDX_W      (IDX_W)
	) u_select (
		.page          (page_s1),
		.frames_in_use (frames_in_use_q),
		.pages         (pages),
		.valid         (valid),
		.rank          (rank),
		.active        (active),
		.dec           (dec),
		.frame_idx     (frame_idx),
		.evicted_page  (evict_page)
	);

	lru_frames #(
		.MAX_FRAMES (MAX_FRAMES),
		.IDX_W      (IDX_W)
	) u_frames (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (valid_s1),
		.dec       (dec),
		.frame_idx (frame_idx),
		.active    (active),
		.page      (page_s1),
		.pages     (pages),
		.valid     (valid),
		.rank      (rank)
	);

	// saturating fault count
	always_comb begin
		fault_count_nxt = fault_count_q;
		if (dec.fault && (fault_count_q != '1)) begin
			fault_count_nxt = fault_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_count_q <= '0;
		end else if (valid_s1) begin
			fault_count_q <= fault_count_nxt;
		end
	end

	assign frame_wide = {{FRAME_W{1'b0}}, frame_idx};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fault_s2         <= dec.fault;
			frame_s2         <= frame_wide[FRAME_W-1:0];
			evicted_valid_s2 <= dec.evict;
			evicted_page_s2  <= evict_page;
			fault_total_s2   <= fault_count_nxt;
		end
	end

	assign done          = done_s2;
	assign fault         = fault_s2;
	assign frame         = frame_s2;
	assign evicted_valid = evicted_valid_s2;
	assign evicted_page  = evicted_page_s2;
	assign fault_total   = fault_total_s2;

	`LRU_ASSERT_IMPLY(a_done_from_request, done, $past(start, 2), "result without a request")
	`LRU_ASSERT_NEXT(a_count_monotonic, 1'b1, fault_count_q >= $past(fault_count_q), "count fell")
	`LRU_ASSERT_IMPLY(a_evict_needs_fault, done && evicted_valid, fault, "eviction reported on a hit")
	`LRU_ASSERT_IMPLY(a_hit_no_evict_page, done && !fault, evicted_page == '0, "evicted page on a hit")

endmodule

@@ hdl/lru_select.sv @@
// ----------------------------------------------------------------------------
// lru_select
// Parallel lookup over all frames: hit search, first empty frame and the
// least recently used victim, producing the frame to use for a request.
// ----------------------------------------------------------------------------
module lru_select import lru_pkg::*; #(
	parameter int MAX_FRAMES = 8,
	parameter int IDX_W      = 3
) (
	input  page_t                   page,
	input  logic [CFG_W-1:0]        frames_in_use,
	input  page_t                   pages   [MAX_FRAMES],
	input  logic [MAX_FRAMES-1:0]   valid,
	input  logic [IDX_W-1:0]        rank    [MAX_FRAMES],
	output logic [MAX_FRAMES-1:0]   active,
	output decision_t               dec,
	output logic [IDX_W-1:0]        frame_idx,
	output page_t                   evicted_page
);

	logic             hit_any;
	logic             empty_any;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] empty_idx;
	logic [IDX_W-1:0] vic_idx;
	logic [IDX_W-1:0] vic_rank;

	// frame 0 is always managed; counts above the frame total clamp naturally
	always_comb begin
		for (int j = 0; j < MAX_FRAMES; j++) begin
			active[j] = (j == 0) || (32'(frames_in_use) > j);
		end
	end

	// descending scans so the lowest matching index wins
	always_comb begin
		hit_any   = 1'b0;
		hit_idx   = '0;
		empty_any = 1'b0;
		empty_idx = '0;
		for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
			if (active[j] && valid[j] && (pages[j] == page)) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(j);
			end
			if (active[j] && !valid[j]) begin
				empty_any = 1'b1;
				empty_idx = IDX_W'(j);
			end
		end
	end

	// oldest managed frame, lowest index on equal ranks
	always_comb begin
		vic_idx  = '0;
		vic_rank = rank[0];
		for (int j = 1; j < MAX_FRAMES; j++) begin
			if (active[j] && (rank[j] > vic_rank)) begin
				vic_idx  = IDX_W'(j);
				vic_rank = rank[j];
			end
		end
	end

	always_comb begin
		dec.fault = !hit_any;
		dec.fill  = !hit_any && empty_any;
		dec.evict = !hit_any && !empty_any;
		if (hit_any) begin
			frame_idx = hit_idx;
		end else if (empty_any) begin
			frame_idx = empty_idx;
		end else begin
			frame_idx = vic_idx;
		end
		evicted_page = dec.evict ? pages[vic_idx] : '0;
	end

endmodule

@@ hdl/lru_frames.sv @@
// ----------------------------------------------------------------------------
// lru_frames
// Frame store: page numbers, valid marks and recency ranks, updated once
// per request from the selection decision.
// ----------------------------------------------------------------------------
module lru_frames import lru_pkg::*; #(
	parameter int MAX_FRAMES = 8,
	parameter int IDX_W      = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    update,
	input  decision_t               dec,
	input  logic [IDX_W-1:0]        frame_idx,
	input  logic [MAX_FRAMES-1:0]   active,
	input  page_t                   page,
	output page_t                   pages   [MAX_FRAMES],
	output logic [MAX_FRAMES-1:0]   valid,
	output logic [IDX_W-1:0]        rank    [MAX_FRAMES]
);

	localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(MAX_FRAMES - 1);

	page_t                 pages_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [IDX_W-1:0]      rank_q  [MAX_FRAMES];
	logic [IDX_W-1:0]      limit;
	logic [MAX_FRAMES-1:0] age;

	// a fill ages every other valid managed frame, a hit or replacement only the younger ones
	always_comb begin
		limit = rank_q[frame_idx];
		for (int j = 0; j < MAX_FRAMES; j++) begin
			age[j] = (IDX_W'(j) != frame_idx) && active[j] && valid_q[j]
				&& (dec.fill || (rank_q[j] < limit)) && (rank_q[j] < RANK_TOP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int j = 0; j < MAX_FRAMES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (update) begin
			if (dec.fill) begin
				valid_q[frame_idx] <= 1'b1;
			end
			for (int j = 0; j < MAX_FRAMES; j++) begin
				if (IDX_W'(j) == frame_idx) begin
					rank_q[j] <= '0;
				end else if (age[j]) begin
					rank_q[j] <= rank_q[j] + 1'b1;
				end
			end
		end
	end

	// page numbers are only looked at while the frame is valid
	always_ff @(posedge clk) begin
		if (update && dec.fault) begin
			pages_q[frame_idx] <= page;
		end
	end

	assign pages = pages_q;
	assign valid = valid_q;
	assign rank  = rank_q;

endmodule
